/* hdl/bayer_bilinear_demosaic_macros.svh */
// Assertion macros shared by the demosaic checker.
`ifndef BAYER_BILINEAR_DEMOSAIC_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define BBD_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also looks at the reset cycles.
`define BBD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/bbd_pkg.sv */
// Shared constants and types of the Bayer bilinear demosaic.
package bbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W     = 8;
    localparam int WID_W     = 12;
    localparam int HGT_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = $clog2(MAX_HEIGHT);

    localparam int SUM_W     = PIX_W + 2;
    localparam int CNT_W     = 3;
    localparam int RECIP3_W  = 10;
    localparam int RECIP3_SH = SUM_W + 1;
    localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(((1 << RECIP3_SH) + 2) / 3);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);

    // 3x3 window taps, row major, top-left first
    localparam int WIN_TL = 0;
    localparam int WIN_T  = 1;
    localparam int WIN_TR = 2;
    localparam int WIN_L  = 3;
    localparam int WIN_C  = 4;
    localparam int WIN_R  = 5;
    localparam int WIN_BL = 6;
    localparam int WIN_B  = 7;
    localparam int WIN_BR = 8;
    localparam int WIN_N  = 9;

    typedef enum logic [1:0] {
        COL_GREEN,
        COL_RED,
        COL_BLUE
    } t_colour;

    typedef logic [PIX_W-1:0] t_pix;

    // Border and colour info of one output pixel
    typedef struct packed {
        logic    top_ok;
        logic    bot_ok;
        logic    left_ok;
        logic    right_ok;
        t_colour own;
        logic    row_odd;
        logic    last;
    } t_pos;

    // One item handed from the front to the back
    typedef struct packed {
        t_pix [WIN_N-1:0] win;
        t_pos             pos;
    } t_cmd;

    // One finished pixel
    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
        logic last;
    } t_rgb;

endpackage

/* hdl/bayer_bilinear_demosaic.sv */
// Top level of the GBRG bilinear Bayer demosaic.
//
// Input channel: raw samples in raster order, written like a queue (push/full).
// i_action selects a sample or a drain tick; after the last sample of a
// frame, image_width+1 drain ticks flush the final row. Drain ticks sent
// while the frame still takes samples are dropped.
// Result channel: read like a queue (empty/pop); one RGB pixel per position
// in raster order, o_frame_end marks the last pixel of the frame.
// A pixel comes out with the item that arrives image_width+1 items after
// its sample; on the way it passes stage B, the item queue, the sum register
// and the result queue. Throughput is one item per cycle while full is low, set
// by the line store (2048 x 16 bits, one read and one write per cycle: read at
// accept, written back in the next cycle). If the receiver stops popping, the
// result queue and the item queue fill and full rises; nothing is lost.
// Reset clears the counters, window and queues and loads 640 x 480; the
// line store needs no clearing. A register write restarts the frame; the
// user makes it only while the block is idle; the block does not enforce this.
module bayer_bilinear_demosaic import bbd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_action,
    input  logic [PIX_W-1:0]     i_raw_sample,
    output logic                 empty,
    input  logic                 pop,
    output logic [PIX_W-1:0]     o_red,
    output logic [PIX_W-1:0]     o_green,
    output logic [PIX_W-1:0]     o_blue,
    output logic                 o_frame_end
);

    logic              q_push, q_pop, q_empty;
    t_cmd              q_cmd_in, q_cmd_out;
    logic [QCNT_W-1:0] q_count;

    bbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_action     (i_action),
        .i_raw_sample (i_raw_sample),
        .o_full       (full),
        .i_q_count    (q_count),
        .o_q_push     (q_push),
        .o_q_cmd      (q_cmd_in)
    );

    bbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    bbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_cmd     (q_cmd_out),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .pop         (pop),
        .empty       (empty),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_frame_end (o_frame_end)
    );

endmodule

/* hdl/bbd_front.sv */
// Front end: frame counters, line store and 3x3 window.
module bbd_front import bbd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_push,
    input  logic                 i_action,
    input  logic [PIX_W-1:0]     i_raw_sample,
    output logic                 o_full,
    input  logic [QCNT_W-1:0]    i_q_count,
    output logic                 o_q_push,
    output t_cmd                 o_q_cmd
);

    logic [WID_W-1:0]  r_width;
    logic [HGT_W-1:0]  r_height;
    logic [EW_W-1:0]   w_eff;
    logic [EH_W-1:0]   h_eff;

    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [IROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [OROW_W-1:0] r_out_row, n_out_row;

    logic              accept, drain, in_frame, work, has_out;
    logic [EW_W-1:0]   in_col_inc, out_col_inc;
    logic [EH_W-1:0]   out_row_inc;
    t_pos              pos;
    t_pix              cur;

    // stage B: line store data comes back
    logic                 r_b_vld;
    logic [COL_W-1:0]     r_b_col;
    logic                 r_b_wr;
    t_pix                 r_b_cur;
    logic                 r_b_out;
    t_pos                 r_b_pos;
    logic                 r_b_byp;
    logic [2*PIX_W-1:0]   r_b_byp_data;

    logic [2*PIX_W-1:0]   r_line [MAX_WIDTH];
    logic [2*PIX_W-1:0]   r_rd;
    logic [2*PIX_W-1:0]   rd_eff;
    t_pix                 up, mid;
    logic                 byp;

    t_pix [WIN_N-1:0]     r_win, n_win;

    // effective frame size, clamped
    always_comb begin
        if (r_width == '0) begin
            w_eff = EW_W'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = EW_W'(MAX_WIDTH);
        end else begin
            w_eff = EW_W'(r_width);
        end
        if (r_height == '0) begin
            h_eff = EH_W'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h_eff = EH_W'(MAX_HEIGHT);
        end else begin
            h_eff = EH_W'(r_height);
        end
    end

    // classify the item
    assign o_full   = ({1'b0, i_q_count} + (QCNT_W+1)'(r_b_vld)) >= (QCNT_W+1)'(QDEPTH);
    assign accept   = i_push && !o_full;
    assign drain    = (i_action == ACT_DRAIN);
    assign in_frame = 32'(r_in_row) < 32'(h_eff);
    assign work     = !(drain && in_frame);
    assign has_out  = (r_in_row >= IROW_W'(2)) || ((r_in_row == IROW_W'(1)) && (r_in_col != '0));
    assign cur      = in_frame ? i_raw_sample : '0;

    assign in_col_inc  = EW_W'(r_in_col) + EW_W'(1);
    assign out_col_inc = EW_W'(r_out_col) + EW_W'(1);
    assign out_row_inc = EH_W'(r_out_row) + EH_W'(1);

    // border flags and colour of the pixel that leaves
    always_comb begin
        pos.top_ok   = (r_out_row != '0);
        pos.bot_ok   = out_row_inc < h_eff;
        pos.left_ok  = (r_out_col != '0);
        pos.right_ok = out_col_inc < w_eff;
        pos.row_odd  = r_out_row[0];
        if (r_out_row[0] == r_out_col[0]) begin
            pos.own = COL_GREEN;
        end else if (r_out_row[0]) begin
            pos.own = COL_RED;
        end else begin
            pos.own = COL_BLUE;
        end
        pos.last = !pos.bot_ok && !pos.right_ok;
    end

    // counter update
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (accept && work) begin
            if (in_col_inc >= w_eff) begin
                n_in_col = '0;
                n_in_row = r_in_row + IROW_W'(1);
            end else begin
                n_in_col = COL_W'(in_col_inc);
            end
            if (has_out) begin
                if (pos.last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (!pos.right_ok) begin
                    n_out_col = '0;
                    n_out_row = OROW_W'(out_row_inc);
                end else begin
                    n_out_col = COL_W'(out_col_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data[WID_W-1:0];
            end else begin
                r_height <= i_cfg_data[HGT_W-1:0];
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // forward a write that lands on the address being read
    assign rd_eff    = r_b_byp ? r_b_byp_data : r_rd;
    assign up        = rd_eff[2*PIX_W-1:PIX_W];
    assign mid       = rd_eff[PIX_W-1:0];
    assign byp       = r_b_vld && r_b_wr && (r_b_col == r_in_col);

    // line store: {upper, middle} per column, read first, written back in the next cycle
    always_ff @(posedge i_clk) begin
        if (accept && work) begin
            r_rd <= r_line[r_in_col];
        end
        if (r_b_vld && r_b_wr) begin
            r_line[r_b_col] <= {mid, r_b_cur};
        end
    end

    // stage B control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= accept && work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && work) begin
            r_b_col      <= r_in_col;
            r_b_wr       <= in_frame;
            r_b_cur      <= cur;
            r_b_out      <= has_out;
            r_b_pos      <= pos;
            r_b_byp      <= byp;
            r_b_byp_data <= {mid, r_b_cur};
        end
    end

    // window shift: new column enters on the right
    always_comb begin
        n_win         = r_win;
        n_win[WIN_TL] = r_win[WIN_T];
        n_win[WIN_T]  = r_win[WIN_TR];
        n_win[WIN_L]  = r_win[WIN_C];
        n_win[WIN_C]  = r_win[WIN_R];
        n_win[WIN_BL] = r_win[WIN_B];
        n_win[WIN_B]  = r_win[WIN_BR];
        n_win[WIN_TR] = up;
        n_win[WIN_R]  = mid;
        n_win[WIN_BR] = r_b_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_win <= '0;
        end else if (r_b_vld) begin
            r_win <= n_win;
        end
    end

    assign o_q_push    = r_b_vld && r_b_out;
    assign o_q_cmd.win = n_win;
    assign o_q_cmd.pos = r_b_pos;

endmodule

/* hdl/bbd_queue.sv */
// Short queue of window items between front and back.
module bbd_queue import bbd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_cmd              i_cmd,
    input  logic              i_pop,
    output t_cmd              o_cmd,
    output logic              o_empty,
    output logic [QCNT_W-1:0] o_count
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hdl/bbd_back.sv */
// Back end: neighbour sums, truncated means and the result queue.
module bbd_back import bbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_q_cmd,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [PIX_W-1:0] o_red,
    output logic [PIX_W-1:0] o_green,
    output logic [PIX_W-1:0] o_blue,
    output logic             o_frame_end
);

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_N     = 3;

    logic [SUM_W-1:0] s_v, s_h, s_x, s_d, s_c;
    logic [CNT_W-1:0] c_v, c_h, c_x, c_d;
    logic             tl_ok, tr_ok, bl_ok, br_ok;

    logic [CH_N-1:0][SUM_W-1:0] n_sum, r_s_sum;
    logic [CH_N-1:0][CNT_W-1:0] n_cnt, r_s_cnt;
    logic                       r_s_vld;
    logic                       r_s_last;

    t_rgb              res;
    t_rgb              r_of [QDEPTH];
    logic [QPTR_W-1:0] r_of_wr, r_of_rd;
    logic [QCNT_W-1:0] r_of_count;
    logic              of_pop;

    function automatic t_pix mean(input logic [SUM_W-1:0] sum, input logic [CNT_W-1:0] cnt);
        logic [SUM_W+RECIP3_W-1:0] prod;
        prod = sum * RECIP3;
        case (cnt)
            CNT_W'(1): mean = sum[PIX_W-1:0];
            CNT_W'(2): mean = sum[PIX_W:1];
            CNT_W'(3): mean = prod[RECIP3_SH +: PIX_W];
            CNT_W'(4): mean = sum[PIX_W+1:2];
            default:   mean = '0;
        endcase
    endfunction

    // masked neighbour groups
    always_comb begin
        tl_ok = i_q_cmd.pos.top_ok && i_q_cmd.pos.left_ok;
        tr_ok = i_q_cmd.pos.top_ok && i_q_cmd.pos.right_ok;
        bl_ok = i_q_cmd.pos.bot_ok && i_q_cmd.pos.left_ok;
        br_ok = i_q_cmd.pos.bot_ok && i_q_cmd.pos.right_ok;
        s_v = (i_q_cmd.pos.top_ok ? SUM_W'(i_q_cmd.win[WIN_T]) : '0)
            + (i_q_cmd.pos.bot_ok ? SUM_W'(i_q_cmd.win[WIN_B]) : '0);
        c_v = CNT_W'(i_q_cmd.pos.top_ok) + CNT_W'(i_q_cmd.pos.bot_ok);
        s_h = (i_q_cmd.pos.left_ok  ? SUM_W'(i_q_cmd.win[WIN_L]) : '0)
            + (i_q_cmd.pos.right_ok ? SUM_W'(i_q_cmd.win[WIN_R]) : '0);
        c_h = CNT_W'(i_q_cmd.pos.left_ok) + CNT_W'(i_q_cmd.pos.right_ok);
        s_x = s_v + s_h;
        c_x = c_v + c_h;
        s_d = (tl_ok ? SUM_W'(i_q_cmd.win[WIN_TL]) : '0)
            + (tr_ok ? SUM_W'(i_q_cmd.win[WIN_TR]) : '0)
            + (bl_ok ? SUM_W'(i_q_cmd.win[WIN_BL]) : '0)
            + (br_ok ? SUM_W'(i_q_cmd.win[WIN_BR]) : '0);
        c_d = CNT_W'(tl_ok) + CNT_W'(tr_ok) + CNT_W'(bl_ok) + CNT_W'(br_ok);
        s_c = SUM_W'(i_q_cmd.win[WIN_C]);
    end

    // pick the groups for each channel by the centre colour
    always_comb begin
        n_sum = '0;
        n_cnt = '0;
        case (i_q_cmd.pos.own)
            COL_GREEN: begin
                n_sum[CH_GREEN] = s_c;
                n_cnt[CH_GREEN] = CNT_W'(1);
                if (i_q_cmd.pos.row_odd) begin
                    n_sum[CH_RED]  = s_h;
                    n_cnt[CH_RED]  = c_h;
                    n_sum[CH_BLUE] = s_v;
                    n_cnt[CH_BLUE] = c_v;
                end else begin
                    n_sum[CH_RED]  = s_v;
                    n_cnt[CH_RED]  = c_v;
                    n_sum[CH_BLUE] = s_h;
                    n_cnt[CH_BLUE] = c_h;
                end
            end
            COL_RED: begin
                n_sum[CH_RED]   = s_c;
                n_cnt[CH_RED]   = CNT_W'(1);
                n_sum[CH_GREEN] = s_x;
                n_cnt[CH_GREEN] = c_x;
                n_sum[CH_BLUE]  = s_d;
                n_cnt[CH_BLUE]  = c_d;
            end
            COL_BLUE: begin
                n_sum[CH_BLUE]  = s_c;
                n_cnt[CH_BLUE]  = CNT_W'(1);
                n_sum[CH_GREEN] = s_x;
                n_cnt[CH_GREEN] = c_x;
                n_sum[CH_RED]   = s_d;
                n_cnt[CH_RED]   = c_d;
            end
            default: begin
                n_sum = '0;
                n_cnt = '0;
            end
        endcase
    end

    // take an item only when the result queue has a slot for it
    assign o_q_pop = !i_q_empty
        && (({1'b0, r_of_count} + (QCNT_W+1)'(r_s_vld)) < (QCNT_W+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s_sum  <= n_sum;
            r_s_cnt  <= n_cnt;
            r_s_last <= i_q_cmd.pos.last;
        end
    end

    // divide stage
    always_comb begin
        res.red   = mean(r_s_sum[CH_RED],   r_s_cnt[CH_RED]);
        res.green = mean(r_s_sum[CH_GREEN], r_s_cnt[CH_GREEN]);
        res.blue  = mean(r_s_sum[CH_BLUE],  r_s_cnt[CH_BLUE]);
        res.last  = r_s_last;
    end

    // result queue
    assign empty  = (r_of_count == '0);
    assign of_pop = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wr    <= '0;
            r_of_rd    <= '0;
            r_of_count <= '0;
        end else begin
            if (r_s_vld) begin
                r_of_wr <= r_of_wr + QPTR_W'(1);
            end
            if (of_pop) begin
                r_of_rd <= r_of_rd + QPTR_W'(1);
            end
            if (r_s_vld && !of_pop) begin
                r_of_count <= r_of_count + QCNT_W'(1);
            end else if (!r_s_vld && of_pop) begin
                r_of_count <= r_of_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_vld) begin
            r_of[r_of_wr] <= res;
        end
    end

    assign o_red       = r_of[r_of_rd].red;
    assign o_green     = r_of[r_of_rd].green;
    assign o_blue      = r_of[r_of_rd].blue;
    assign o_frame_end = r_of[r_of_rd].last;

endmodule

/* hdl/bbd_checker.sv */
// Port-level checker of the demosaic, bound to the top level.
`include "bayer_bilinear_demosaic_macros.svh"

module bbd_checker import bbd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 push,
    input logic                 full,
    input logic                 i_action,
    input logic [PIX_W-1:0]     i_raw_sample,
    input logic                 empty,
    input logic                 pop,
    input logic [PIX_W-1:0]     o_red,
    input logic [PIX_W-1:0]     o_green,
    input logic [PIX_W-1:0]     o_blue,
    input logic                 o_frame_end
);

    // reset leaves no result waiting and room for input
    `BBD_ASSERT_RST(a_rst_empty, !i_rst_n |=> empty, "result pending after reset")
    `BBD_ASSERT_RST(a_rst_room, !i_rst_n |=> !full, "full after reset")

    // a waiting result holds until taken
    `BBD_ASSERT_CLK(a_hold, !empty && !pop |=> !empty && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_frame_end), "result changed while waiting")

    // backpressure only builds from accepted items
    `BBD_ASSERT_CLK(a_full_cause, !full && !push |=> !full, "full rose with no item pushed")

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (.*);
